FILE: design/point_material_classifier_macros.svh
// assertion helpers used by the classifier
`ifndef POINT_MATERIAL_CLASSIFIER_MACROS_SVH
`define POINT_MATERIAL_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pmc_pkg.sv
package pmc_pkg;

    // default build parameters
    localparam int PMC_MAX_OBJECTS      = 64;
    localparam int PMC_WORDS_PER_OBJECT = 32;
    localparam int PMC_FRAC_BITS        = 16;

    localparam int WORD_W    = 32;
    localparam int REC_WORDS = 25;
    localparam int Q_W       = 34;
    localparam int SLOT_FW   = 6;

    // record word offsets
    localparam int WD_KIND   = 0;
    localparam int WD_MAT    = 1;
    localparam int WD_CENTER = 2;
    localparam int WD_RADIUS = 5;
    localparam int WD_HEIGHT = 6;
    localparam int WD_AXIS   = 7;
    localparam int WD_PROJ   = 10;
    localparam int WD_SIZE   = 19;
    localparam int WD_ISA    = 22;

    // shape kinds
    localparam logic [1:0] KIND_SPHERE    = 2'd0;
    localparam logic [1:0] KIND_CYLINDER  = 2'd1;
    localparam logic [1:0] KIND_BOX       = 2'd2;
    localparam logic [1:0] KIND_ELLIPSOID = 2'd3;

    // operation codes
    localparam logic [1:0] OP_WRITE_OBJ    = 2'd0;
    localparam logic [1:0] OP_WRITE_METRIC = 2'd1;
    localparam logic [1:0] OP_CLASSIFY     = 2'd2;
    localparam logic [1:0] OP_NOP          = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_OBJECT_COUNT     = 3'd0;
    localparam logic [2:0] CFG_DEFAULT_MATERIAL = 3'd1;
    localparam logic [2:0] CFG_PERIODIC_CHECK   = 3'd2;
    localparam logic [2:0] CFG_LATTICE_DIMS     = 3'd3;
    localparam logic [2:0] CFG_LATTICE_SIZE_X   = 3'd4;
    localparam logic [2:0] CFG_LATTICE_SIZE_Y   = 3'd5;
    localparam logic [2:0] CFG_LATTICE_SIZE_Z   = 3'd6;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         obj_slot;
        logic [4:0]         word_sel;
        logic signed [31:0] word_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } pmc_in_t;

    typedef struct packed {
        logic [7:0] material_id;
        logic       hit;
        logic [5:0] hit_slot;
    } pmc_out_t;

    typedef logic [REC_WORDS-1:0][WORD_W-1:0] pmc_rec_t;
    typedef logic [8:0][WORD_W-1:0]           pmc_mat_t;

    typedef struct packed {
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
    } pmc_point_t;

    // status from the containment unit
    typedef struct packed {
        logic done;
        logic contained;
    } pmc_test_t;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'sd2147483647) begin
            y = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // true when 2*|v| > lim
    function automatic logic half_exceeds(input logic signed [31:0] v,
                                          input logic signed [31:0] lim);
        logic signed [34:0] mag;
        logic signed [34:0] lim_x;
        mag   = v[31] ? -{{3{v[31]}}, v} : {3'b000, v};
        mag   = mag <<< 1;
        lim_x = {{3{lim[31]}}, lim};
        return mag > lim_x;
    endfunction

endpackage

FILE: design/pmc_inside.sv
module pmc_inside
    import pmc_pkg::*;
#(
    parameter int FRAC_BITS = PMC_FRAC_BITS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  pmc_point_t q,
    input  pmc_rec_t   rec,
    input  pmc_mat_t   metric,
    output pmc_test_t  res
);

    typedef enum logic [2:0] {
        I_IDLE = 3'b001,
        I_MUL  = 3'b010,
        I_ACC  = 3'b100
    } ist_t;

    localparam logic [4:0] MV_STEPS = 5'd9;

    ist_t               ist_reg, ist_next;
    logic [4:0]         step_reg, step_next;
    logic [1:0]         col_reg, col_next;
    logic [1:0]         row_reg, row_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg;
    logic signed [31:0] r_reg [3];
    logic signed [31:0] r_next [3];
    logic signed [31:0] v_reg [3];
    logic signed [31:0] v_next [3];
    logic signed [31:0] t_reg [3];
    logic signed [31:0] t_next [3];
    logic signed [31:0] proj_reg, proj_next;
    pmc_test_t          res_reg, res_next;

    logic [1:0]         kind;
    logic signed [31:0] rad;
    logic signed [31:0] height;
    logic signed [31:0] center [3];
    logic signed [31:0] axis [3];
    logic signed [31:0] box_size [3];
    logic signed [31:0] isa [3];
    logic signed [Q_W-1:0] qv [3];
    pmc_mat_t           mat_sel;
    logic [4:0]         e;
    logic signed [31:0] op_a, op_b;
    logic signed [63:0] prod_full;
    logic signed [63:0] sum;
    logic signed [63:0] one_q;
    logic signed [31:0] proj_sat;

    // record fields
    always_comb begin
        kind   = rec[WD_KIND][1:0];
        rad    = rec[WD_RADIUS];
        height = rec[WD_HEIGHT];
        for (int i = 0; i < 3; i++) begin
            center[i]   = rec[WD_CENTER + i];
            axis[i]     = rec[WD_AXIS + i];
            box_size[i] = rec[WD_SIZE + i];
            isa[i]      = rec[WD_ISA + i];
        end
        qv[0] = q.x;
        qv[1] = q.y;
        qv[2] = q.z;
        mat_sel = (kind == KIND_SPHERE || kind == KIND_CYLINDER) ?
                  metric : pmc_mat_t'(rec[WD_PROJ+8:WD_PROJ]);
    end

    assign e     = step_reg - MV_STEPS;
    assign one_q = 64'sd1 <<< FRAC_BITS;

    // operand selection for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (step_reg < MV_STEPS) begin
            op_a = mat_sel[step_reg[3:0]];
            op_b = r_reg[col_reg];
        end else begin
            case (kind)
                KIND_SPHERE: begin
                    if (e < 5'd3) begin
                        op_a = r_reg[col_reg];
                        op_b = v_reg[col_reg];
                    end else begin
                        op_a = rad;
                        op_b = rad;
                    end
                end
                KIND_CYLINDER: begin
                    if (e < 5'd3) begin
                        op_a = axis[col_reg];
                        op_b = v_reg[col_reg];
                    end else if (e < 5'd6) begin
                        op_a = r_reg[col_reg];
                        op_b = v_reg[col_reg];
                    end else if (e == 5'd6) begin
                        op_a = proj_reg;
                        op_b = proj_reg;
                    end else begin
                        op_a = rad;
                        op_b = rad;
                    end
                end
                KIND_ELLIPSOID: begin
                    if (e < 5'd3) begin
                        op_a = v_reg[col_reg];
                        op_b = isa[col_reg];
                    end else begin
                        op_a = t_reg[col_reg];
                        op_b = t_reg[col_reg];
                    end
                end
                default: begin
                    op_a = '0;
                    op_b = '0;
                end
            endcase
        end
    end

    assign prod_full = op_a * op_b;
    assign sum       = acc_reg + prod_reg;
    assign proj_sat  = sat32(sum);

    // step sequencer
    always_comb begin
        logic fin;
        logic hit;
        fin        = 1'b0;
        hit        = 1'b0;
        ist_next   = ist_reg;
        step_next  = step_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        acc_next   = acc_reg;
        proj_next  = proj_reg;
        res_next   = '0;
        for (int i = 0; i < 3; i++) begin
            r_next[i] = r_reg[i];
            v_next[i] = v_reg[i];
            t_next[i] = t_reg[i];
        end
        case (ist_reg)
            I_IDLE: begin
                if (start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_next[i] = sat32(64'(qv[i]) - 64'(center[i]));
                    end
                    acc_next  = '0;
                    step_next = '0;
                    col_next  = '0;
                    row_next  = '0;
                    ist_next  = I_MUL;
                end
            end
            I_MUL: begin
                ist_next = I_ACC;
            end
            I_ACC: begin
                col_next = (col_reg == 2'd2) ? 2'd0 : col_reg + 2'd1;
                if (step_reg < MV_STEPS) begin
                    // matrix times offset, one row per three products
                    if (col_reg == 2'd2) begin
                        v_next[row_reg] = sat32(sum);
                        acc_next        = '0;
                        row_next        = row_reg + 2'd1;
                    end else begin
                        acc_next = sum;
                    end
                end else begin
                    case (kind)
                        KIND_SPHERE: begin
                            if (e < 5'd3) begin
                                acc_next = sum;
                            end else begin
                                fin = 1'b1;
                                hit = (rad > 32'sd0) && (acc_reg <= prod_reg);
                            end
                        end
                        KIND_CYLINDER: begin
                            if (e < 5'd2) begin
                                acc_next = sum;
                            end else if (e == 5'd2) begin
                                // axial projection and height check
                                proj_next = proj_sat;
                                acc_next  = '0;
                                if (half_exceeds(proj_sat, height)) begin
                                    fin = 1'b1;
                                end
                            end else if (e < 5'd6) begin
                                acc_next = sum;
                            end else if (e == 5'd6) begin
                                acc_next = acc_reg - prod_reg;
                            end else begin
                                fin = 1'b1;
                                hit = (rad > 32'sd0) && (acc_reg <= prod_reg);
                            end
                        end
                        KIND_ELLIPSOID: begin
                            if (e < 5'd3) begin
                                t_next[col_reg] = sat32(prod_reg);
                            end else if (e < 5'd5) begin
                                acc_next = sum;
                            end else begin
                                fin = 1'b1;
                                hit = (sum <= one_q);
                            end
                        end
                        default: begin
                            fin = 1'b1;
                            hit = !half_exceeds(v_reg[0], box_size[0]) &&
                                  !half_exceeds(v_reg[1], box_size[1]) &&
                                  !half_exceeds(v_reg[2], box_size[2]);
                        end
                    endcase
                end
                if (fin) begin
                    res_next.done      = 1'b1;
                    res_next.contained = hit;
                    ist_next           = I_IDLE;
                end else begin
                    step_next = step_reg + 5'd1;
                    ist_next  = I_MUL;
                end
            end
            default: begin
                ist_next = I_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ist_reg <= I_IDLE;
            res_reg <= '0;
        end else begin
            ist_reg <= ist_next;
            res_reg <= res_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        acc_reg  <= acc_next;
        proj_reg <= proj_next;
        prod_reg <= prod_full >>> FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            r_reg[i] <= r_next[i];
            v_reg[i] <= v_next[i];
            t_reg[i] <= t_next[i];
        end
    end

    assign res = res_reg;

endmodule

FILE: design/point_material_classifier.sv
// channel   | signals                        | transaction
// ----------+--------------------------------+--------------------------------
// input     | s_valid s_ready s_data         | object word, metric word, query
// result    | m_valid m_ready m_data         | material, hit, slot (queries)
// config    | cfg_wr_en cfg_index cfg_wr_data| one register write per cycle
//
// a query loads, per object tested, its record word by word from the object memory,
// then tests each point with a matrix product and a shape check, all through the
// single shared multiplier; with periodic checking up to 28 points per object. a
// finished result sits in the output register while the next transaction is taken.
// reset is synchronous, active low; the object memory is not cleared, the metric
// resets to identity.
`include "point_material_classifier_macros.svh"

module point_material_classifier
    import pmc_pkg::*;
#(
    parameter int MAX_OBJECTS      = PMC_MAX_OBJECTS,
    parameter int WORDS_PER_OBJECT = PMC_WORDS_PER_OBJECT,
    parameter int FRAC_BITS        = PMC_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pmc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pmc_out_t    m_data,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);

    localparam int DEPTH  = MAX_OBJECTS * WORDS_PER_OBJECT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;
    localparam logic [4:0]  LAST_WORD = 5'(REC_WORDS - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_LWAIT = 6'b000100,
        S_START = 6'b001000,
        S_TEST  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // configuration registers
    logic [6:0]         object_count_reg;
    logic [7:0]         default_material_reg;
    logic               periodic_check_reg;
    logic [1:0]         lattice_dims_reg;
    logic signed [31:0] lattice_size_x_reg;
    logic signed [31:0] lattice_size_y_reg;
    logic signed [31:0] lattice_size_z_reg;
    pmc_mat_t           metric_reg;

    // object memory
    logic [WORD_W-1:0]  table_mem [DEPTH];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [4:0]         wcnt_reg, wcnt_next;
    logic               ld_valid_reg, ld_valid_next;
    logic [4:0]         ld_word_reg, ld_word_next;
    pmc_rec_t           rec_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic               base_reg, base_next;
    logic [1:0]         di_reg, di_next, dj_reg, dj_next, dk_reg, dk_next;
    pmc_point_t         q_reg, q_next;
    logic               start_reg, start_next;
    pmc_out_t           res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    pmc_out_t           m_data_reg, m_data_next;
    pmc_test_t          tres;

    logic               accept;
    logic [1:0]         jmin, jmax, kmin, kmax;
    logic               last_shift;
    logic [31:0]        n_sel;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // shift ranges per active dimension
    assign jmin = (lattice_dims_reg >= 2'd2) ? 2'd0 : 2'd1;
    assign jmax = (lattice_dims_reg >= 2'd2) ? 2'd2 : 2'd1;
    assign kmin = (lattice_dims_reg == 2'd3) ? 2'd0 : 2'd1;
    assign kmax = (lattice_dims_reg == 2'd3) ? 2'd2 : 2'd1;
    assign last_shift = (di_reg == 2'd2) && (dj_reg == jmax) && (dk_reg == kmax);

    assign n_sel = (32'(object_count_reg) > 32'(MAX_OBJECTS)) ?
                   32'(MAX_OBJECTS) : 32'(object_count_reg);

    // memory addressing
    assign wr_en   = accept && (s_data.op == OP_WRITE_OBJ) &&
                     (32'(s_data.obj_slot) < 32'(MAX_OBJECTS)) &&
                     (32'(s_data.word_sel) < 32'(WORDS_PER_OBJECT));
    assign wr_addr = ADDR_W'(32'(s_data.obj_slot) * 32'(WORDS_PER_OBJECT) +
                             32'(s_data.word_sel));
    assign rd_addr = ADDR_W'(32'(slot_reg) * 32'(WORDS_PER_OBJECT) + 32'(wcnt_reg));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= s_data.word_value;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    // record capture from the read port, and query point capture
    always_ff @(posedge aclk) begin
        if (ld_valid_reg) begin
            rec_reg[ld_word_reg] <= rd_data_reg;
        end
        if (accept) begin
            px_reg <= s_data.point_x;
            py_reg <= s_data.point_y;
            pz_reg <= s_data.point_z;
        end
    end

    // lattice offset for one shift code
    function automatic logic signed [Q_W-1:0] shift_off(input logic [1:0] code,
                                                        input logic signed [31:0] size);
        logic signed [Q_W-1:0] s;
        s = Q_W'(size);
        if (code == 2'd0) begin
            return -s;
        end else if (code == 2'd2) begin
            return s;
        end
        return '0;
    endfunction

    // query sequencer
    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        wcnt_next     = wcnt_reg;
        ld_valid_next = 1'b0;
        ld_word_next  = wcnt_reg;
        base_next     = base_reg;
        di_next       = di_reg;
        dj_next       = dj_reg;
        dk_next       = dk_reg;
        q_next        = q_reg;
        start_next    = 1'b0;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && s_data.op == OP_CLASSIFY) begin
                    if (n_sel == 32'd0) begin
                        res_next.material_id = default_material_reg;
                        res_next.hit         = 1'b0;
                        res_next.hit_slot    = '0;
                        state_next           = S_DONE;
                    end else begin
                        slot_next  = SLOT_W'(n_sel - 32'd1);
                        wcnt_next  = '0;
                        base_next  = 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                ld_valid_next = 1'b1;
                if (wcnt_reg == LAST_WORD) begin
                    state_next = S_LWAIT;
                end else begin
                    wcnt_next = wcnt_reg + 5'd1;
                end
            end
            S_LWAIT: begin
                state_next = S_START;
            end
            S_START: begin
                // exact point, shifted by the lattice offset except in the base test
                if (base_reg) begin
                    q_next.x = Q_W'(px_reg);
                    q_next.y = Q_W'(py_reg);
                    q_next.z = Q_W'(pz_reg);
                end else begin
                    q_next.x = Q_W'(px_reg) + shift_off(di_reg, lattice_size_x_reg);
                    q_next.y = Q_W'(py_reg) + shift_off(dj_reg, lattice_size_y_reg);
                    q_next.z = Q_W'(pz_reg) + shift_off(dk_reg, lattice_size_z_reg);
                end
                start_next = 1'b1;
                state_next = S_TEST;
            end
            S_TEST: begin
                if (tres.done) begin
                    if (tres.contained) begin
                        res_next.material_id = rec_reg[WD_MAT][7:0];
                        res_next.hit         = 1'b1;
                        res_next.hit_slot    = SLOT_FW'(slot_reg);
                        state_next           = S_DONE;
                    end else if (base_reg && periodic_check_reg &&
                                 lattice_dims_reg != 2'd0) begin
                        base_next  = 1'b0;
                        di_next    = 2'd0;
                        dj_next    = jmin;
                        dk_next    = kmin;
                        state_next = S_START;
                    end else if (!base_reg && !last_shift) begin
                        // step z fastest, then y, then x
                        if (dk_reg != kmax) begin
                            dk_next = dk_reg + 2'd1;
                        end else begin
                            dk_next = kmin;
                            if (dj_reg != jmax) begin
                                dj_next = dj_reg + 2'd1;
                            end else begin
                                dj_next = jmin;
                                di_next = di_reg + 2'd1;
                            end
                        end
                        state_next = S_START;
                    end else if (slot_reg == '0) begin
                        res_next.material_id = default_material_reg;
                        res_next.hit         = 1'b0;
                        res_next.hit_slot    = '0;
                        state_next           = S_DONE;
                    end else begin
                        slot_next  = slot_reg - SLOT_W'(1);
                        wcnt_next  = '0;
                        base_next  = 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ld_valid_reg <= 1'b0;
            start_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ld_valid_reg <= ld_valid_next;
            start_reg    <= start_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // sequencer payload
    always_ff @(posedge aclk) begin
        slot_reg    <= slot_next;
        wcnt_reg    <= wcnt_next;
        ld_word_reg <= ld_word_next;
        base_reg    <= base_next;
        di_reg      <= di_next;
        dj_reg      <= dj_next;
        dk_reg      <= dk_next;
        q_reg       <= q_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    // configuration and metric writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            object_count_reg     <= '0;
            default_material_reg <= '0;
            periodic_check_reg   <= 1'b0;
            lattice_dims_reg     <= 2'd3;
            lattice_size_x_reg   <= ONE_Q;
            lattice_size_y_reg   <= ONE_Q;
            lattice_size_z_reg   <= ONE_Q;
            for (int i = 0; i < 9; i++) begin
                metric_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q : '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_OBJECT_COUNT:     object_count_reg     <= cfg_wr_data[6:0];
                    CFG_DEFAULT_MATERIAL: default_material_reg <= cfg_wr_data[7:0];
                    CFG_PERIODIC_CHECK:   periodic_check_reg   <= cfg_wr_data[0];
                    CFG_LATTICE_DIMS:     lattice_dims_reg     <= cfg_wr_data[1:0];
                    CFG_LATTICE_SIZE_X:   lattice_size_x_reg   <= cfg_wr_data;
                    CFG_LATTICE_SIZE_Y:   lattice_size_y_reg   <= cfg_wr_data;
                    CFG_LATTICE_SIZE_Z:   lattice_size_z_reg   <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (accept && s_data.op == OP_WRITE_METRIC && s_data.word_sel < 5'd9) begin
                metric_reg[s_data.word_sel[3:0]] <= s_data.word_value;
            end
        end
    end

    // containment test unit
    pmc_inside #(
        .FRAC_BITS (FRAC_BITS)
    ) u_inside (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .q       (q_reg),
        .rec     (rec_reg),
        .metric  (metric_reg),
        .res     (tres)
    );

    // checks
    `PMC_ASSERT_NOW(a_miss_slot_zero, aclk, aresetn, m_valid && !m_data.hit, m_data.hit_slot == '0, "miss result carries a nonzero slot")
    `PMC_ASSERT_NOW(a_test_done_in_test, aclk, aresetn, tres.done, state_reg == S_TEST, "containment result outside the test phase")
    `PMC_ASSERT_NOW(a_load_in_phase, aclk, aresetn, ld_valid_reg, state_reg == S_LOAD || state_reg == S_LWAIT, "record word captured outside a load")
    `PMC_ASSERT_NEXT(a_result_drains, aclk, aresetn, m_valid && m_ready && state_reg != S_DONE, !m_valid, "result repeated after it was taken")

endmodule
